[hdl/dtt_pkg.sv]
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants for the delimited text tokenizer
// Holds the byte codes, the token kinds, the register indexes and the
// configuration and result structs.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] LfByte    = 8'd10;
  localparam logic [ByteW-1:0] CrByte    = 8'd13;
  localparam logic [ByteW-1:0] QuoteByte = 8'd34;

  localparam logic [ByteW-1:0] DelimReset   = 8'd44;
  localparam logic [ByteW-1:0] CommentReset = 8'd35;

  typedef enum logic [KindW-1:0] {
    KIND_CHAR         = 2'd0,
    KIND_WORD_END     = 2'd1,
    KIND_WORD_ROW_END = 2'd2,
    KIND_ROW_END      = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DELIMITER    = 2'd0,
    REG_QUOTE_MODE   = 2'd1,
    REG_COMMENT_MODE = 2'd2,
    REG_COMMENT_BYTE = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] delimiter_byte;
    logic             quote_mode;
    logic             comment_mode;
    logic [ByteW-1:0] comment_byte;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    kind_e            token_kind;
    logic [ByteW-1:0] word_byte;
  } res_t;

endpackage

[hdl/dtt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dtt_cfg_regs: configuration registers
// Four write-only registers loaded by index from the plain write port.
// ----------------------------------------------------------------------------
module dtt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dtt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dtt_pkg::ByteW-1:0]     cfg_data_i,
  output dtt_pkg::cfg_t                 cfg_o
);
  import dtt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DELIMITER:    cfg_d.delimiter_byte = cfg_data_i;
        REG_QUOTE_MODE:   cfg_d.quote_mode     = cfg_data_i[0];
        REG_COMMENT_MODE: cfg_d.comment_mode   = cfg_data_i[0];
        REG_COMMENT_BYTE: cfg_d.comment_byte   = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter_byte <= DelimReset;
      cfg_q.quote_mode     <= 1'b0;
      cfg_q.comment_mode   <= 1'b0;
      cfg_q.comment_byte   <= CommentReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/dtt_core.sv]
// ----------------------------------------------------------------------------
// dtt_core: tokenizer state and byte decode
// Classifies one byte against the current line state, gives the result
// token and advances the four state bits when the byte is consumed.
// ----------------------------------------------------------------------------
module dtt_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dtt_pkg::cfg_t             cfg_i,
  input  logic [dtt_pkg::ByteW-1:0] text_byte_i,
  input  logic                      fire_i,
  output dtt_pkg::res_t             res_o
);
  import dtt_pkg::*;

  logic quotes_q, quotes_d;
  logic word_open_q, word_open_d;
  logic skip_q, skip_d;
  logic had_words_q, had_words_d;

  logic quoted;
  logic close_word;
  logic emit_char;
  res_t res;

  always_comb begin
    quoted      = cfg_i.quote_mode && quotes_q;
    close_word  = 1'b0;
    emit_char   = 1'b0;
    quotes_d    = quotes_q;
    word_open_d = word_open_q;
    skip_d      = skip_q;
    had_words_d = had_words_q;
    res         = '{valid: 1'b0, token_kind: KIND_CHAR, word_byte: '0};

    if (text_byte_i == LfByte) begin
      // line end wins over every other role
      if (word_open_q) begin
        res.valid      = 1'b1;
        res.token_kind = KIND_WORD_ROW_END;
      end else if (had_words_q) begin
        res.valid      = 1'b1;
        res.token_kind = KIND_ROW_END;
      end
      word_open_d = 1'b0;
      skip_d      = 1'b0;
      had_words_d = 1'b0;
    end else if (skip_q) begin
      // rest of line ignored
    end else if (quoted) begin
      if (text_byte_i == QuoteByte) begin
        quotes_d = 1'b0;
      end else if (text_byte_i == CrByte) begin
        skip_d     = 1'b1;
        close_word = 1'b1;
      end else begin
        emit_char = 1'b1;
      end
    end else if (cfg_i.comment_mode && text_byte_i == cfg_i.comment_byte) begin
      skip_d     = 1'b1;
      close_word = 1'b1;
    end else if (cfg_i.quote_mode && text_byte_i == QuoteByte) begin
      quotes_d = 1'b1;
    end else if (text_byte_i == cfg_i.delimiter_byte) begin
      close_word = 1'b1;
    end else if (text_byte_i == CrByte) begin
      skip_d     = 1'b1;
      close_word = 1'b1;
    end else begin
      emit_char = 1'b1;
    end

    if (close_word && word_open_q) begin
      word_open_d    = 1'b0;
      had_words_d    = 1'b1;
      res.valid      = 1'b1;
      res.token_kind = KIND_WORD_END;
    end
    if (emit_char) begin
      word_open_d    = 1'b1;
      res.valid      = 1'b1;
      res.token_kind = KIND_CHAR;
      res.word_byte  = text_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quotes_q    <= 1'b0;
      word_open_q <= 1'b0;
      skip_q      <= 1'b0;
      had_words_q <= 1'b0;
    end else if (fire_i) begin
      quotes_q    <= quotes_d;
      word_open_q <= word_open_d;
      skip_q      <= skip_d;
      had_words_q <= had_words_d;
    end
  end

  assign res_o = res;

  a_lf_clears_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && text_byte_i == LfByte |=> !word_open_q && !skip_q && !had_words_q)
    else $error("line state not cleared after line feed");

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q && text_byte_i != LfByte |-> !res_o.valid)
    else $error("token produced while skipping to line end");

  a_end_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.token_kind != KIND_CHAR |-> res_o.word_byte == '0)
    else $error("end token carries a nonzero byte");

  a_quotes_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !cfg_i.quote_mode |=> $stable(quotes_q))
    else $error("quote state changed with quote handling off");

endmodule

[hdl/delimited_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// delimited_text_tokenizer: streaming tokenizer for delimited text
// Turns a byte stream into word characters, word ends and row ends.
// ----------------------------------------------------------------------------
//   channel   | dir | tdata           | tuser
//   s_axis    | in  | text_byte[7:0]  | -
//   m_axis    | out | word_byte[7:0]  | token_kind[1:0]
//   cfg       | in  | 4 registers by index, write only
//
// one byte per cycle while a stalled m_axis does not back up; each beat is
// decoded and updates the line state in the input register, then its token
// lands in the result register.
// bytes that give no token never wait on the output side.
// reset clears the line state and loads the register defaults.
// a stalled m_axis holds its beat and backs up into s_axis only when the
// waiting byte would produce a token.
// ----------------------------------------------------------------------------
module delimited_text_tokenizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dtt_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] text_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dtt_pkg::ByteW-1:0]   m_axis_tdata,   // [7:0] word_byte
  output logic [dtt_pkg::KindW-1:0]   m_axis_tuser,   // [1:0] token_kind
  input  logic                        cfg_we_i,
  input  logic [dtt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dtt_pkg::ByteW-1:0]   cfg_data_i
);
  import dtt_pkg::*;

  cfg_t             cfg;
  res_t             res;
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q, out_vld_d;
  kind_e            out_kind_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_free;
  logic             fire;
  logic             s_take;

  dtt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dtt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .text_byte_i (in_byte_q),
    .fire_i      (fire),
    .res_o       (res)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && (out_free || !res.valid);
  assign s_axis_tready = !in_vld_q || fire;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire && res.valid) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (fire && res.valid) begin
      out_kind_q <= res.token_kind;
      out_byte_q <= res.word_byte;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

[verif/token_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_checker: scoreboard for the delimited text tokenizer
// Watches the text, token and register ports. It keeps its own copy of the
// register values and the line state, works out the token that each accepted
// text byte gives, and compares every token beat with the oldest one waiting.
// ----------------------------------------------------------------------------
module token_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [dtt_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] text_byte
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [dtt_pkg::ByteW-1:0]   m_axis_tdata,   // [7:0] word_byte
  input  logic [dtt_pkg::KindW-1:0]   m_axis_tuser,   // [1:0] token_kind
  input  logic                        cfg_we_i,
  input  logic [dtt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dtt_pkg::ByteW-1:0]   cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import dtt_pkg::*;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] wbyte;
  } token_t;

  token_t           tokens_q[$];
  token_t           exp_tok;
  int unsigned      fails;

  logic [ByteW-1:0] delim;
  logic             quote_on;
  logic             comment_on;
  logic [ByteW-1:0] cbyte;

  logic             in_quotes;
  logic             word_open;
  logic             skipping;
  logic             line_words;

  function automatic void push_token(kind_e k, logic [ByteW-1:0] b);
    token_t t;
    t.kind  = k;
    t.wbyte = b;
    tokens_q.push_back(t);
  endfunction

  // mid-line close of the current word
  function automatic void close_word();
    if (word_open) begin
      word_open  = 1'b0;
      line_words = 1'b1;
      push_token(KIND_WORD_END, '0);
    end
  endfunction

  function automatic void tokenize_byte(logic [ByteW-1:0] b);
    logic quoted;
    quoted = quote_on && in_quotes;
    if (b == LfByte) begin
      // newline ends the line whatever the registers say, quotes survive it
      if (word_open) begin
        push_token(KIND_WORD_ROW_END, '0);
      end else if (line_words) begin
        push_token(KIND_ROW_END, '0);
      end
      word_open  = 1'b0;
      skipping   = 1'b0;
      line_words = 1'b0;
    end else if (skipping) begin
      // rest of line ignored
    end else if (quoted) begin
      if (b == QuoteByte) begin
        in_quotes = 1'b0;
      end else if (b == CrByte) begin
        skipping = 1'b1;
        close_word();
      end else begin
        word_open = 1'b1;
        push_token(KIND_CHAR, b);
      end
    end else if (comment_on && b == cbyte) begin
      skipping = 1'b1;
      close_word();
    end else if (quote_on && b == QuoteByte) begin
      in_quotes = 1'b1;
    end else if (b == delim) begin
      close_word();
    end else if (b == CrByte) begin
      skipping = 1'b1;
      close_word();
    end else begin
      word_open = 1'b1;
      push_token(KIND_CHAR, b);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim      = DelimReset;
      quote_on   = 1'b0;
      comment_on = 1'b0;
      cbyte      = CommentReset;
      in_quotes  = 1'b0;
      word_open  = 1'b0;
      skipping   = 1'b0;
      line_words = 1'b0;
      fails      = 0;
      tokens_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tokens_q.size() == 0) begin
          $display("%0t: unexpected token beat, expected none, got kind %0d byte 0x%02h",
                   $time, m_axis_tuser, m_axis_tdata);
          fails++;
        end else begin
          exp_tok = tokens_q.pop_front();
          if (m_axis_tuser !== exp_tok.kind) begin
            $display("%0t: token_kind mismatch, expected %0d, got %0d",
                     $time, exp_tok.kind, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata !== exp_tok.wbyte) begin
            $display("%0t: word_byte mismatch, expected 0x%02h, got 0x%02h",
                     $time, exp_tok.wbyte, m_axis_tdata);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_DELIMITER:    delim      = cfg_data_i;
          REG_QUOTE_MODE:   quote_on   = cfg_data_i[0];
          REG_COMMENT_MODE: comment_on = cfg_data_i[0];
          REG_COMMENT_BYTE: cbyte      = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tokenize_byte(s_axis_tdata);
      end
      fail_count_o <= fails;
      pending_o    <= tokens_q.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream test of the delimited text tokenizer
// Sends a short hand-written text through the reset settings and the quote
// modes, then mostly well-formed random lines with noise under a series of
// register settings, with random gaps and stalls on both streams, a long
// token-side hold and a drain before each register change.
// ----------------------------------------------------------------------------
module testbench;
  import dtt_pkg::*;

  localparam int unsigned RandomTarget = 1500;
  localparam int unsigned PhaseBytes   = 110;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned CycleLimit   = 400000;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata  = '0;   // [7:0] text_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ByteW-1:0]   m_axis_tdata;         // [7:0] word_byte
  logic [KindW-1:0]   m_axis_tuser;         // [1:0] token_kind
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [ByteW-1:0]   cfg_data_i    = '0;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        cycle_count   = 0;
  int unsigned        bytes_sent    = 0;
  logic               no_idle       = 1'b0;
  logic               hold_req      = 1'b0;

  // settings the line generator works with
  logic [ByteW-1:0]   cur_delim     = DelimReset;
  logic               cur_quote     = 1'b0;
  logic               cur_comment   = 1'b0;
  logic [ByteW-1:0]   cur_cbyte     = CommentReset;

  delimited_text_tokenizer dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  token_checker u_token_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // stop sending and wait until every token has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [ByteW-1:0] d, input logic q, input logic c,
                              input logic [ByteW-1:0] cb);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_DELIMITER;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_idx_i  <= REG_QUOTE_MODE;
    cfg_data_i <= ByteW'(q);
    @(posedge clk_i);
    cfg_idx_i  <= REG_COMMENT_MODE;
    cfg_data_i <= ByteW'(c);
    @(posedge clk_i);
    cfg_idx_i  <= REG_COMMENT_BYTE;
    cfg_data_i <= cb;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_delim   = d;
    cur_quote   = q;
    cur_comment = c;
    cur_cbyte   = cb;
  endtask

  // any byte with no special role under the current settings
  function automatic logic [ByteW-1:0] plain_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(0, 255));
    while (b == LfByte || b == CrByte || b == QuoteByte || b == cur_delim ||
           (cur_comment && b == cur_cbyte));
    return b;
  endfunction

  task automatic send_line();
    int unsigned shape;
    int unsigned nfields;
    int unsigned f;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      // noise, may hold quotes, CR or stray delimiters
      repeat ($urandom_range(1, 8)) send_byte(ByteW'($urandom_range(0, 255)));
    end else if (shape == 1) begin
      repeat ($urandom_range(0, 3)) send_byte(plain_byte());
      send_byte(cur_cbyte);
      repeat ($urandom_range(0, 4)) send_byte(ByteW'($urandom_range(0, 255)));
    end else begin
      nfields = $urandom_range(1, 5);
      for (f = 0; f < nfields; f++) begin
        if (f > 0) send_byte(cur_delim);
        if (cur_quote && $urandom_range(0, 2) == 0) begin
          send_byte(QuoteByte);
          repeat ($urandom_range(0, 4)) begin
            send_byte(($urandom_range(0, 3) == 0) ? cur_delim : plain_byte());
          end
          send_byte(QuoteByte);
        end else begin
          repeat ($urandom_range(0, 4)) send_byte(plain_byte());
        end
      end
    end
    if ($urandom_range(0, 3) == 0) send_byte(CrByte);
    send_byte(LfByte);
  endtask

  // token side: random stall per beat, one long hold on request
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int unsigned phase;
    int unsigned rand_start;
    int unsigned phase_start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: byte extremes, empty fields, CR skip, row ends
    send_text("a");
    send_byte(8'h00);
    send_byte(8'hff);
    send_text(",,\rz\n\n\"#\n");
    // quotes across a line, data delimiter and comment byte inside quotes
    apply_config(DelimReset, 1'b1, 1'b1, CommentReset);
    send_text("\",\n#\"#b\n");
    // CR inside quotes, then quote mode off while still quoted
    send_text("\"q\r\n");
    apply_config(DelimReset, 1'b0, 1'b0, CommentReset);
    send_text("\"\n");

    rand_start = bytes_sent;
    phase = 0;
    while (bytes_sent - rand_start < RandomTarget) begin
      case (phase)
        0: apply_config(8'd0, 1'b1, 1'b1, 8'd255);
        1: apply_config(8'd255, 1'b0, 1'b1, 8'd0);
        2: apply_config(LfByte, 1'b1, 1'b1, LfByte);
        3: apply_config(QuoteByte, 1'b1, 1'b1, QuoteByte);
        4: apply_config(QuoteByte, 1'b1, 1'b0, CommentReset);
        5: apply_config(CrByte, 1'b1, 1'b0, CommentReset);
        6: apply_config(DelimReset, 1'b0, 1'b1, DelimReset);
        7: apply_config(DelimReset, 1'b1, 1'b1, CommentReset);
        default: begin
          apply_config($urandom_range(0, 1) ? DelimReset : ByteW'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 1) ? CommentReset : ByteW'($urandom_range(0, 255)));
        end
      endcase
      if (phase == 7) begin
        // token side holds while text keeps coming, so the input backs up
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_byte(plain_byte());
      end
      no_idle = ($urandom_range(0, 3) == 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_line();
      phase++;
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
